>>> src/fujt_pkg.sv
// Package: shared types, character codes and hex decode for the form-urlencoded converter.
`timescale 1ns / 1ps

package fujt_pkg;

    // Parse phase of the current message
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TEXT  = 2'd1,
        PH_HEX1  = 2'd2,
        PH_HEX2  = 2'd3
    } phase_t;

    // Parser state carried from one item to the next
    typedef struct packed {
        phase_t     phase;
        logic [3:0] hex_val;
        logic       hex_ok;
    } parse_state_t;

    // Most result bytes one item can cause
    localparam int MAX_RES = 9;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int IDX_W   = $clog2(MAX_RES);

    // Result bytes of one item, first byte at index 0
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
    } res_list_t;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QM    = 8'h3F;

    // Decode one hex digit: bit 4 set when valid, low nibble its value (zero if invalid)
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

>>> src/fujt_expand.sv
// Expander: turns one input byte and the parser state into its result bytes and next state.
`timescale 1ns / 1ps

module fujt_expand (
    input  logic [7:0]             in_byte,
    input  logic                   fin,
    input  fujt_pkg::parse_state_t st,
    output fujt_pkg::parse_state_t st_next,
    output fujt_pkg::res_list_t    list
);
    import fujt_pkg::*;

    logic [3:0]      pre_n;
    logic [2:0]      body_n;
    logic [3:0][7:0] body;
    logic [4:0]      hx;
    logic [3:0]      rel_body;
    logic [3:0]      rel_sfx;

    assign hx = hex_decode(in_byte);

    // Decode the body bytes and advance the parser
    always_comb
    begin
        body    = '0;
        body_n  = 3'd0;
        st_next = st;
        pre_n   = (st.phase == PH_START) ? 4'd2 : 4'd0;
        unique case (st.phase)
            PH_HEX1:
            begin
                st_next.hex_ok  = hx[4];
                st_next.hex_val = hx[3:0];
                st_next.phase   = PH_HEX2;
                if (fin)
                begin
                    body[0] = hx[4] ? {4'd0, hx[3:0]} : CH_QM;
                    body_n  = 3'd1;
                end
            end
            PH_HEX2:
            begin
                body_n = 3'd1;
                if (!st.hex_ok)
                    body[0] = CH_QM;
                else if (hx[4])
                    body[0] = {st.hex_val, hx[3:0]};
                else
                    body[0] = {4'd0, st.hex_val};
                st_next.phase = PH_TEXT;
            end
            PH_START, PH_TEXT:
            begin
                st_next.phase = PH_TEXT;
                priority if (in_byte == CH_PLUS)
                begin
                    body[0] = CH_SP;
                    body_n  = 3'd1;
                end
                else if (in_byte == CH_PCT)
                begin
                    st_next.phase = PH_HEX1;
                    if (fin)
                    begin
                        body[0] = CH_QM;
                        body_n  = 3'd1;
                    end
                end
                else if (in_byte == CH_AMP)
                begin
                    body   = {CH_QUOTE, CH_NL, CH_COMMA, CH_QUOTE};
                    body_n = 3'd4;
                end
                else if (in_byte == CH_EQ)
                begin
                    body   = {8'd0, CH_QUOTE, CH_COLON, CH_QUOTE};
                    body_n = 3'd3;
                end
                else
                begin
                    body[0] = in_byte;
                    body_n  = 3'd1;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
        // Close the message and return to its start
        if (fin)
        begin
            st_next.phase   = PH_START;
            st_next.hex_val = 4'd0;
            st_next.hex_ok  = 1'b0;
        end
    end

    // Lay out prefix, body and suffix into one list
    always_comb
    begin
        rel_body   = 4'd0;
        rel_sfx    = 4'd0;
        list.bytes = '0;
        list.count = CNT_W'(pre_n + {1'b0, body_n} + (fin ? 4'd3 : 4'd0));
        for (int i = 0; i < MAX_RES; i++)
        begin
            rel_body = 4'(i) - pre_n;
            rel_sfx  = rel_body - {1'b0, body_n};
            if (4'(i) < pre_n)
                list.bytes[i] = (i == 0) ? CH_NL : CH_QUOTE;
            else if (rel_body < {1'b0, body_n})
                list.bytes[i] = body[rel_body[1:0]];
            else if (rel_sfx == 4'd0)
                list.bytes[i] = CH_QUOTE;
            else if (rel_sfx == 4'd1)
                list.bytes[i] = CH_COMMA;
            else
                list.bytes[i] = CH_NL;
        end
    end

endmodule

>>> src/form_urlencoded_to_json_text_top.sv
// Top level: form-urlencoded body to JSON-like text converter with percent decoding.
//
//  channel  dir  tdata                 tlast            tuser
//  s_axis   in   [7:0] in_byte         end_of_message   -
//  m_axis   out  [7:0] out_byte        out_last         -
//
// Each input item expands into 0 to 9 result bytes, which leave one per cycle while m_tready
// is high; a plain byte inside a message passes at one item per cycle unless the output stalls,
// while '&', '=', the first byte of a message and message ends cause more than one byte each.
// A pending list register sits in front of the emit register, so the next item is taken while the
// current list still drains.
// Reset clears the parser to the start of a message and empties both list registers.
// A stall on the output holds the emit register; input stalls only once both are full.
`timescale 1ns / 1ps

module form_urlencoded_to_json_text_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);
    import fujt_pkg::*;

    parse_state_t st_reg, st_next;
    res_list_t    new_list;
    res_list_t    pend_reg;
    res_list_t    emit_reg;
    logic         pend_vld_reg, pend_vld_next;
    logic         emit_vld_reg, emit_vld_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic         s_acc, load, move, emit_done;

    fujt_expand u_expand (
        .in_byte (s_tdata),
        .fin     (s_tlast),
        .st      (st_reg),
        .st_next (st_next),
        .list    (new_list)
    );

    // Handshake and list movement
    assign m_tvalid  = emit_vld_reg;
    assign m_tdata   = emit_reg.bytes[idx_reg];
    assign m_tlast   = (CNT_W'(idx_reg) + CNT_W'(1)) == emit_reg.count;
    assign emit_done = emit_vld_reg && m_tready && m_tlast;
    assign move      = pend_vld_reg && (!emit_vld_reg || emit_done);
    assign s_tready  = !pend_vld_reg || move;
    assign s_acc     = s_tvalid && s_tready;
    assign load      = s_acc && (new_list.count != '0);

    // Next valid flags and read index
    always_comb
    begin
        pend_vld_next = load ? 1'b1 : (move ? 1'b0 : pend_vld_reg);
        if (move)
            emit_vld_next = 1'b1;
        else if (emit_done)
            emit_vld_next = 1'b0;
        else
            emit_vld_next = emit_vld_reg;
        if (move || emit_done)
            idx_next = '0;
        else if (emit_vld_reg && m_tready)
            idx_next = idx_reg + IDX_W'(1);
        else
            idx_next = idx_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= '{phase: PH_START, hex_val: 4'd0, hex_ok: 1'b0};
            pend_vld_reg <= 1'b0;
            emit_vld_reg <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            if (s_acc)
                st_reg <= st_next;
            pend_vld_reg <= pend_vld_next;
            emit_vld_reg <= emit_vld_next;
            idx_reg      <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            pend_reg <= new_list;
        if (move)
            emit_reg <= pend_reg;
    end

    // Read index stays inside the list being emitted
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_vld_reg |-> (CNT_W'(idx_reg) < emit_reg.count))
        else $error("emit index past end of list");

    // A stored list is never empty
    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (pend_reg.count != '0))
        else $error("empty list held pending");

    // Input stalls only with both list registers full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (pend_vld_reg && emit_vld_reg))
        else $error("input stalled with free list register");

    // A stalled output byte holds its place
    a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_vld_reg && !m_tready) |=> ($stable(idx_reg) && emit_vld_reg))
        else $error("emit index moved during stall");

endmodule

>>> sim/form_urlencoded_to_json_text_top_tb.sv
// Testbench: directed table and random urlencoded messages checked against a byte-level predictor.
`timescale 1ns / 1ps

module form_urlencoded_to_json_text_top_tb;

    import fujt_pkg::*;

    localparam int N_ITEMS    = 310;
    localparam int N_TABLE    = 25;
    localparam int CALM_START = 270;
    localparam int CYCLE_CAP  = 200000;
    localparam int PRINT_CAP  = 40;

    // One row of the directed table; txt holds the typed result bytes, first byte highest
    typedef struct packed {
        logic [7:0]  data;
        logic        fin;
        logic        lit;
        logic [3:0]  n;
        logic [71:0] txt;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predictor state
    phase_t     cur_phase = PH_START;
    logic [3:0] esc_val = 4'h0;
    logic       esc_ok = 1'b0;

    // Text bytes produced by one item, and the queue of text still due ({last, byte})
    logic [7:0] step_text[$];
    logic [8:0] due_text[$];
    logic [8:0] due_head;

    dir_row_t   dir_tab [N_TABLE];
    int         sent = 0;
    int         errors = 0;
    int         cycles = 0;
    int         hold_cnt = 0;
    bit         idle_on = 1'b0;

    form_urlencoded_to_json_text_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d bytes still due", cycles, due_text.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report(input string msg);
        errors++;
        // keep the log short on a badly broken build
        if (errors <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic dir_row_t row(input logic [7:0] d, input logic f, input logic l,
                                     input logic [3:0] n, input logic [71:0] txt);
        row = '{data: d, fin: f, lit: l, n: n, txt: txt};
    endfunction

    function automatic logic [7:0] pick_hex();
        case ($urandom_range(0, 2))
            0:       pick_hex = 8'($urandom_range(48, 57));
            1:       pick_hex = 8'($urandom_range(97, 102));
            default: pick_hex = 8'($urandom_range(65, 70));
        endcase
    endfunction

    // Classify one escape digit candidate
    task automatic digit_of(input logic [7:0] c, output logic ok, output logic [3:0] v);
        ok = 1'b1;
        v  = 4'h0;
        if (c >= "0" && c <= "9")
            v = 4'(c - "0");
        else if (c >= "a" && c <= "f")
            v = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F")
            v = 4'(c - "A" + 8'd10);
        else
            ok = 1'b0;
    endtask

    // Convert one input byte into the text it causes, advancing the parser state
    task automatic convert_byte(input logic [7:0] b, input logic fin);
        logic       ok;
        logic [3:0] v;
        step_text.delete();
        if (cur_phase == PH_START)
        begin
            step_text.push_back(CH_NL);
            step_text.push_back(CH_QUOTE);
            cur_phase = PH_TEXT;
        end
        case (cur_phase)
            PH_HEX1:
            begin
                digit_of(b, ok, v);
                esc_ok    = ok;
                esc_val   = v;
                cur_phase = PH_HEX2;
                // message ends on the first digit: emit what is known
                if (fin)
                    step_text.push_back(esc_ok ? {4'h0, esc_val} : CH_QM);
            end
            PH_HEX2:
            begin
                digit_of(b, ok, v);
                if (!esc_ok)
                    step_text.push_back(CH_QM);
                else if (ok)
                    step_text.push_back({esc_val, v});
                else
                    step_text.push_back({4'h0, esc_val});
                cur_phase = PH_TEXT;
            end
            default:
            begin
                if (b == CH_PLUS)
                    step_text.push_back(CH_SP);
                else if (b == CH_PCT)
                begin
                    cur_phase = PH_HEX1;
                    if (fin)
                        step_text.push_back(CH_QM);
                end
                else if (b == CH_AMP)
                begin
                    step_text.push_back(CH_QUOTE);
                    step_text.push_back(CH_COMMA);
                    step_text.push_back(CH_NL);
                    step_text.push_back(CH_QUOTE);
                end
                else if (b == CH_EQ)
                begin
                    step_text.push_back(CH_QUOTE);
                    step_text.push_back(CH_COLON);
                    step_text.push_back(CH_QUOTE);
                end
                else
                    step_text.push_back(b);
            end
        endcase
        if (fin)
        begin
            step_text.push_back(CH_QUOTE);
            step_text.push_back(CH_COMMA);
            step_text.push_back(CH_NL);
            cur_phase = PH_START;
            esc_val   = 4'h0;
            esc_ok    = 1'b0;
        end
    endtask

    // Queue the text of one item, present it and wait for the handshake
    task automatic send_item(input logic [7:0] d, input logic fin, input logic lit,
                             input logic [3:0] n, input logic [71:0] txt);
        int i;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        convert_byte(d, fin);
        // typed rows replace the predicted text
        if (lit)
        begin
            step_text.delete();
            for (i = 0; i < n; i++)
                step_text.push_back(txt[8 * (n - 1 - i) +: 8]);
        end
        for (i = 0; i < step_text.size(); i++)
            due_text.push_back({i == step_text.size() - 1, step_text[i]});
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        sent++;
    endtask

    // Output stall bursts
    always @(posedge clk)
    begin
        if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            hold_cnt <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each output item with the oldest due byte
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_text.size() == 0)
                report($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
            else
            begin
                due_head = due_text.pop_front();
                if (m_tdata !== due_head[7:0])
                    report($sformatf("byte %02h, want %02h", m_tdata, due_head[7:0]));
                if (m_tlast !== due_head[8])
                    report($sformatf("last %0b, want %0b on byte %02h",
                                     m_tlast, due_head[8], due_head[7:0]));
            end
        end
    end

    initial
    begin
        logic [7:0] msg[$];
        int         i;
        int         target;

        // Directed table: plain text, separators, escapes, byte extremes, ends inside escapes
        dir_tab[0]  = row("a",    1'b0, 1'b1, 4'd3, "\n\"a");
        dir_tab[1]  = row(CH_PLUS, 1'b0, 1'b1, 4'd1, " ");
        dir_tab[2]  = row(CH_EQ,  1'b0, 1'b1, 4'd3, "\":\"");
        dir_tab[3]  = row(CH_AMP, 1'b0, 1'b1, 4'd4, "\",\n\"");
        dir_tab[4]  = row(CH_PCT, 1'b0, 1'b1, 4'd0, "");
        dir_tab[5]  = row("4",    1'b0, 1'b1, 4'd0, "");
        dir_tab[6]  = row("1",    1'b0, 1'b1, 4'd1, "A");
        dir_tab[7]  = row(CH_PCT, 1'b0, 1'b0, 4'd0, "");
        dir_tab[8]  = row("g",    1'b0, 1'b0, 4'd0, "");
        dir_tab[9]  = row("1",    1'b0, 1'b1, 4'd1, "?");
        dir_tab[10] = row(CH_PCT, 1'b0, 1'b0, 4'd0, "");
        dir_tab[11] = row("F",    1'b0, 1'b0, 4'd0, "");
        dir_tab[12] = row("z",    1'b0, 1'b0, 4'd0, "");
        dir_tab[13] = row(CH_PCT, 1'b0, 1'b0, 4'd0, "");
        dir_tab[14] = row("f",    1'b0, 1'b0, 4'd0, "");
        dir_tab[15] = row("F",    1'b0, 1'b0, 4'd0, "");
        dir_tab[16] = row(8'hFF,  1'b0, 1'b0, 4'd0, "");
        dir_tab[17] = row(8'h00,  1'b0, 1'b0, 4'd0, "");
        dir_tab[18] = row(CH_PCT, 1'b1, 1'b1, 4'd4, "?\",\n");
        dir_tab[19] = row(CH_PCT, 1'b0, 1'b1, 4'd2, "\n\"");
        dir_tab[20] = row("B",    1'b1, 1'b0, 4'd0, "");
        dir_tab[21] = row(CH_AMP, 1'b1, 1'b1, 4'd9, "\n\"\",\n\"\",\n");
        dir_tab[22] = row(CH_PCT, 1'b0, 1'b0, 4'd0, "");
        dir_tab[23] = row("7",    1'b0, 1'b0, 4'd0, "");
        dir_tab[24] = row(CH_PCT, 1'b1, 1'b0, 4'd0, "");

        // Hold reset low before releasing it
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        for (i = 0; i < N_TABLE; i++)
            send_item(dir_tab[i].data, dir_tab[i].fin, dir_tab[i].lit, dir_tab[i].n,
                      dir_tab[i].txt);

        // Random part: mostly well-formed messages, some noise
        while (sent < N_ITEMS)
        begin
            msg.delete();
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: any byte, final flag at random
                target = $urandom_range(1, 6);
                for (i = 0; i < target; i++)
                    msg.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                target = $urandom_range(1, 14);
                while (msg.size() < target)
                begin
                    case ($urandom_range(0, 11))
                        0, 1, 2: msg.push_back(8'($urandom_range(97, 122)));
                        3:       msg.push_back(8'($urandom_range(48, 57)));
                        4:       msg.push_back(8'($urandom_range(65, 90)));
                        5:       msg.push_back(CH_PLUS);
                        6:       msg.push_back(CH_EQ);
                        7:       msg.push_back(CH_AMP);
                        8, 9:
                        begin
                            msg.push_back(CH_PCT);
                            msg.push_back(pick_hex());
                            msg.push_back(pick_hex());
                        end
                        10:
                        begin
                            msg.push_back(CH_PCT);
                            msg.push_back(8'($urandom_range(0, 255)));
                            msg.push_back(8'($urandom_range(0, 255)));
                        end
                        default: msg.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                // end some messages inside an escape
                case ($urandom_range(0, 7))
                    0: msg.push_back(CH_PCT);
                    1:
                    begin
                        msg.push_back(CH_PCT);
                        msg.push_back(pick_hex());
                    end
                    2:
                    begin
                        msg.push_back(CH_PCT);
                        msg.push_back(8'($urandom_range(0, 255)));
                    end
                    default: ;
                endcase
            end
            for (i = 0; i < msg.size(); i++)
            begin
                // stretches without idling, and none at all near the end
                idle_on = (sent < CALM_START) && ((sent / 40) % 3 != 2);
                send_item(msg[i], (i == msg.size() - 1) || ($urandom_range(0, 15) == 0),
                          1'b0, 4'd0, 72'd0);
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow for stray output
        while (due_text.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
